[rtl/mmg_pkg.sv]
// ----------------------------------------------------------------------------
// mmg_pkg: shared types, constants and helpers of the model matrix generator
// Fixed-point constants (Q.30), the CORDIC arctangent table and the rounded
// Q.30 product.
// ----------------------------------------------------------------------------
package mmg_pkg;

  localparam int CordicW = 34;       // CORDIC x/y/z width, Q.30 plus headroom
  localparam int TrigW   = 32;       // sine/cosine width, Q.30
  localparam int AtanEntries = 24;

  localparam logic signed [CordicW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;

  // Cosine and sine of one angle, Q.30
  typedef struct packed {
    logic signed [TrigW-1:0] cos;
    logic signed [TrigW-1:0] sin;
  } trig_t;

  function automatic logic signed [CordicW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CordicW-1:0] v;
    case (idx)
      5'd0:    v = 34'sh03243F6A8;
      5'd1:    v = 34'sh01DAC6705;
      5'd2:    v = 34'sh00FADBAFC;
      5'd3:    v = 34'sh007F56EA6;
      5'd4:    v = 34'sh003FEAB76;
      5'd5:    v = 34'sh001FFD55B;
      5'd6:    v = 34'sh000FFFAAA;
      5'd7:    v = 34'sh0007FFF55;
      5'd8:    v = 34'sh0003FFFEA;
      5'd9:    v = 34'sh0001FFFFD;
      5'd10:   v = 34'sh0000FFFFF;
      5'd11:   v = 34'sh00007FFFF;
      5'd12:   v = 34'sh00003FFFF;
      5'd13:   v = 34'sh00001FFFF;
      5'd14:   v = 34'sh00000FFFF;
      5'd15:   v = 34'sh000007FFF;
      5'd16:   v = 34'sh000003FFF;
      5'd17:   v = 34'sh000001FFF;
      5'd18:   v = 34'sh000000FFF;
      5'd19:   v = 34'sh0000007FF;
      5'd20:   v = 34'sh0000003FF;
      5'd21:   v = 34'sh0000001FF;
      5'd22:   v = 34'sh0000000FF;
      5'd23:   v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Rounded Q.30 product; magnitudes stay near 1.0 so 32 bits hold the result
  function automatic logic signed [TrigW-1:0] mulq30(input logic signed [TrigW-1:0] a,
                                                     input logic signed [TrigW-1:0] b);
    logic signed [2*TrigW-1:0] p;
    logic signed [2*TrigW-1:0] r;
    p = a * b;
    r = (p + 64'sd536870912) >>> 30;
    return r[TrigW-1:0];
  endfunction

endpackage

[rtl/mmg_cordic.sv]
// ----------------------------------------------------------------------------
// mmg_cordic: pipelined rotation-mode CORDIC
// Quadrant fold, one register stage per iteration, sign-restore stage.
// ----------------------------------------------------------------------------
module mmg_cordic #(
  parameter int ITER = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [15:0]  angle,
  output mmg_pkg::trig_t      trig
);

  localparam int W = mmg_pkg::CordicW;

  logic signed [W-1:0] x [ITER+1];
  logic signed [W-1:0] y [ITER+1];
  logic signed [W-1:0] z [ITER+1];
  logic                flip [ITER+1];

  logic signed [34:0]  za;
  logic signed [34:0]  zf;
  logic                fold;
  logic signed [W-1:0] xo;
  logic signed [W-1:0] yo;

  // widen Q3.13 to Q.30 and fold into the range of convergence
  assign za = {{2{angle[15]}}, angle, 17'b0};
  always_comb begin
    fold = 1'b0;
    zf   = za;
    if (za > mmg_pkg::Q30_HALF_PI) begin
      fold = 1'b1;
      zf   = za - mmg_pkg::Q30_PI;
    end else if (za < -mmg_pkg::Q30_HALF_PI) begin
      fold = 1'b1;
      zf   = za + mmg_pkg::Q30_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= mmg_pkg::CORDIC_GAIN;
      y[0]    <= '0;
      z[0]    <= zf[W-1:0];
      flip[0] <= fold;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!z[i][W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - mmg_pkg::atan_q30(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + mmg_pkg::atan_q30(5'(i));
        end
      end
    end
  end

  // undo the fold by negating both results
  assign xo = flip[ITER] ? -x[ITER] : x[ITER];
  assign yo = flip[ITER] ? -y[ITER] : y[ITER];

  always_ff @(posedge clk) begin
    if (en) begin
      trig.cos <= xo[mmg_pkg::TrigW-1:0];
      trig.sin <= yo[mmg_pkg::TrigW-1:0];
    end
  end

endmodule

[rtl/mmg_rot.sv]
// ----------------------------------------------------------------------------
// mmg_rot: rotation matrix products and column scaling
// Four stages: pair products, triple products, sums, scale and round.
// ----------------------------------------------------------------------------
module mmg_rot (
  input  logic                clk,
  input  logic                en,
  input  mmg_pkg::trig_t      tx,
  input  mmg_pkg::trig_t      ty,
  input  mmg_pkg::trig_t      tz,
  input  logic signed [15:0]  scl [3],
  output logic signed [31:0]  elem [9]
);

  localparam int TW = mmg_pkg::TrigW;

  // stage 1
  logic signed [TW-1:0] czcy, czsy, szsy, szcx, szsx, czcx, czsx, cysx, cycx, sy1, cx1, sx1, szcy;
  logic signed [15:0]   scl1 [3];
  // stage 2
  logic signed [TW-1:0] czsysx, czsycx, szsysx, szsycx;
  logic signed [TW-1:0] czcy2, szcx2, szsx2, szcy2, czcx2, czsx2, cysx2, cycx2, sy2;
  logic signed [15:0]   scl2 [3];
  // stage 3
  logic signed [TW:0]   r [9];
  logic signed [15:0]   scl3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      czcy <= mmg_pkg::mulq30(tz.cos, ty.cos);
      czsy <= mmg_pkg::mulq30(tz.cos, ty.sin);
      szsy <= mmg_pkg::mulq30(tz.sin, ty.sin);
      szcy <= mmg_pkg::mulq30(tz.sin, ty.cos);
      szcx <= mmg_pkg::mulq30(tz.sin, tx.cos);
      szsx <= mmg_pkg::mulq30(tz.sin, tx.sin);
      czcx <= mmg_pkg::mulq30(tz.cos, tx.cos);
      czsx <= mmg_pkg::mulq30(tz.cos, tx.sin);
      cysx <= mmg_pkg::mulq30(ty.cos, tx.sin);
      cycx <= mmg_pkg::mulq30(ty.cos, tx.cos);
      sy1  <= ty.sin;
      cx1  <= tx.cos;
      sx1  <= tx.sin;
      scl1 <= scl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      czsysx <= mmg_pkg::mulq30(czsy, sx1);
      czsycx <= mmg_pkg::mulq30(czsy, cx1);
      szsysx <= mmg_pkg::mulq30(szsy, sx1);
      szsycx <= mmg_pkg::mulq30(szsy, cx1);
      czcy2  <= czcy;
      szcy2  <= szcy;
      szcx2  <= szcx;
      szsx2  <= szsx;
      czcx2  <= czcx;
      czsx2  <= czsx;
      cysx2  <= cysx;
      cycx2  <= cycx;
      sy2    <= sy1;
      scl2   <= scl1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= (TW+1)'(czcy2);
      r[1] <= (TW+1)'(czsysx) - (TW+1)'(szcx2);
      r[2] <= (TW+1)'(czsycx) + (TW+1)'(szsx2);
      r[3] <= (TW+1)'(szcy2);
      r[4] <= (TW+1)'(szsysx) + (TW+1)'(czcx2);
      r[5] <= (TW+1)'(szsycx) - (TW+1)'(czsx2);
      r[6] <= -(TW+1)'(sy2);
      r[7] <= (TW+1)'(cysx2);
      r[8] <= (TW+1)'(cycx2);
      scl3 <= scl2;
    end
  end

  // Q.30 times Q8.8, rounded to Q16.16; the 27-bit result never reaches the
  // 32-bit limits, so saturation reduces to sign extension
  for (genvar e = 0; e < 9; e++) begin : g_scale
    logic signed [TW+16:0] p;
    logic signed [TW+16:0] q;
    assign p = r[e] * scl3[e % 3];
    assign q = (p + (TW+17)'(49'sd2097152)) >>> 22;
    always_ff @(posedge clk) begin
      if (en) begin
        elem[e] <= q[TW-1:0];
      end
    end
  end

endmodule

[rtl/model_matrix_generate.sv]
// ----------------------------------------------------------------------------
// model_matrix_generate: T * Rz * Ry * Rx * S model matrix, top three rows
// Three CORDIC lanes give sine and cosine of each angle, a product pipeline
// forms the rotation elements, each scaled by its column's factor.
//
//  Channel   Dir  Width  Contents
//  s_*       in   192    pos_x, pos_y, pos_z, angle_x/y/z, scale_x/y/z
//  m_*       out  384    m_r0_c0 .. m_r2_c3, row major
//
//  One transfer is taken per cycle unless the output stalls; most of the
//  latency comes from the CORDIC chain, one register stage per iteration.
//  The whole pipeline advances together; when the output holds a result that
//  is not taken, every stage holds and s_tready drops.
//  rst clears only the valid bits; data registers carry no reset.
// ----------------------------------------------------------------------------
module model_matrix_generate #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x[31:0] pos_y[63:32] pos_z[95:64] angle_x[111:96] angle_y[127:112]
  // angle_z[143:128] scale_x[159:144] scale_y[175:160] scale_z[191:176]
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_r0_c0..m_r0_c3 [127:0], m_r1_c0..m_r1_c3 [255:128],
  // m_r2_c0..m_r2_c3 [383:256], 32 bits each, column 0 lowest
  output logic [383:0] m_tdata
);

  localparam int CLAT = CORDIC_ITERATIONS + 2;  // CORDIC latency
  localparam int LAT  = CLAT + 4;               // total latency

  logic                en;
  logic [LAT-1:0]      vld;
  logic [95:0]         pos_d [LAT];
  logic signed [15:0]  scl_d [CLAT][3];
  logic signed [15:0]  scl_in [3];
  logic signed [31:0]  elem [9];
  mmg_pkg::trig_t      tx, ty, tz;

  // advance all stages when the output stage is empty or being drained
  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // side data travels alongside the CORDIC and product stages
  always_ff @(posedge clk) begin
    if (en) begin
      pos_d[0]    <= s_tdata[95:0];
      scl_d[0][0] <= s_tdata[159:144];
      scl_d[0][1] <= s_tdata[175:160];
      scl_d[0][2] <= s_tdata[191:176];
      for (int k = 1; k < LAT; k++) begin
        pos_d[k] <= pos_d[k-1];
      end
      for (int k = 1; k < CLAT; k++) begin
        scl_d[k] <= scl_d[k-1];
      end
    end
  end

  assign scl_in = scl_d[CLAT-1];

  mmg_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_x (
    .clk(clk), .en(en), .angle(s_tdata[111:96]), .trig(tx)
  );
  mmg_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_y (
    .clk(clk), .en(en), .angle(s_tdata[127:112]), .trig(ty)
  );
  mmg_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_z (
    .clk(clk), .en(en), .angle(s_tdata[143:128]), .trig(tz)
  );

  mmg_rot u_rot (
    .clk(clk), .en(en), .tx(tx), .ty(ty), .tz(tz), .scl(scl_in), .elem(elem)
  );

  // pack rows; translation forms the fourth column
  assign m_tdata = {pos_d[LAT-1][95:64], elem[8], elem[7], elem[6],
                    pos_d[LAT-1][63:32], elem[5], elem[4], elem[3],
                    pos_d[LAT-1][31:0],  elem[2], elem[1], elem[0]};

endmodule

[rtl/mmg_checker.sv]
// ----------------------------------------------------------------------------
// mmg_checker: port-level checks of the model matrix generator
// Reset behavior, output hold under stall and the shared pipeline advance.
// ----------------------------------------------------------------------------
module mmg_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [383:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stage");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while pipeline stalled");

endmodule

bind model_matrix_generate mmg_checker u_mmg_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
